// File: sv/vgu_pkg.sv
package vgu_pkg;

    // coordinate format
    localparam int COORD_WIDTH = 24;
    localparam int CW          = COORD_WIDTH;
    localparam int IN_DATA_W   = ((6 * CW + 7) / 8) * 8;

    // internal widths
    localparam int DIFF_W   = CW + 1;
    localparam int PROD_W   = 2 * CW;
    localparam int MAG_W    = 2 * CW + 1;
    localparam int VEC_W    = MAG_W + 1;
    localparam int DOT_W    = 2 * CW + 2;
    localparam int SPLIT_LO = MAG_W - MAG_W / 2;
    localparam int SPLIT_HI = MAG_W / 2;
    localparam int HH_W     = 2 * SPLIT_HI;
    localparam int HL_W     = SPLIT_HI + SPLIT_LO;
    localparam int LL_W     = 2 * SPLIT_LO;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUM_W    = 2 * MAG_W;
    localparam int WIDE_W   = SUM_W + 1;
    localparam int ROOT_W   = MAG_W;
    localparam int REM_W    = ROOT_W + 3;

    // result format
    localparam int UNIT_FRAC = 30;
    localparam int QUO_W     = UNIT_FRAC + 1;
    localparam int OUT_W     = 32;
    localparam int SCALAR_W  = 64;
    localparam int OUT_DATA_W = 3 * OUT_W + SCALAR_W;
    localparam logic [QUO_W-1:0] UNIT_ONE = {1'b1, {UNIT_FRAC{1'b0}}};

    typedef enum logic [2:0] {
        ACT_UNIT_DIFF  = 3'd0,
        ACT_UNIT_CROSS = 3'd1,
        ACT_UNIT_A     = 3'd2,
        ACT_DOT        = 3'd3,
        ACT_DIST_SQ    = 3'd4,
        ACT_DIST       = 3'd5
    } action_t;

    // side data through the square root
    typedef struct packed {
        action_t                  action;
        logic [2:0]               neg;
        logic [2:0][MAG_W-1:0]    mag;
        logic [SCALAR_W-1:0]      scalar;
    } sq_pay_t;

    // side data through the divider
    typedef struct packed {
        action_t             action;
        logic [2:0]          neg;
        logic                zero;
        logic [SCALAR_W-1:0] scalar;
    } div_pay_t;

    // one digit of the square root
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [SUM_W-1:0]  rad;
    } sqrt_st_t;

    function automatic sqrt_st_t sqrt_step(sqrt_st_t cur);
        sqrt_st_t         nxt;
        logic [REM_W-1:0] shifted;
        logic [REM_W-1:0] trial;
        shifted = {cur.rem[REM_W-3:0], cur.rad[SUM_W-1 -: 2]};
        trial   = {1'b0, cur.root, 2'b01};
        nxt.rad = {cur.rad[SUM_W-3:0], 2'b00};
        if (shifted >= trial) begin
            nxt.rem  = shifted - trial;
            nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
        end else begin
            nxt.rem  = shifted;
            nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

    // one quotient bit: returns {bit, new remainder}
    function automatic logic [MAG_W:0] div_step(logic [MAG_W-1:0] rem,
                                                logic [MAG_W-1:0] den,
                                                logic bit_in);
        logic [MAG_W:0] shifted;
        logic [MAG_W:0] diff;
        logic [MAG_W:0] res;
        shifted = {rem, bit_in};
        diff    = shifted - {1'b0, den};
        if (shifted >= {1'b0, den}) begin
            res = {1'b1, diff[MAG_W-1:0]};
        end else begin
            res = {1'b0, shifted[MAG_W-1:0]};
        end
        return res;
    endfunction

    // clamp a signed value to the 64-bit range
    function automatic logic [SCALAR_W-1:0] sat_s64(logic [WIDE_W-1:0] v);
        logic [SCALAR_W-1:0] r;
        if (v[WIDE_W-1:SCALAR_W-1] == {(WIDE_W-SCALAR_W+1){v[SCALAR_W-1]}}) begin
            r = v[SCALAR_W-1:0];
        end else if (v[WIDE_W-1]) begin
            r = {1'b1, {(SCALAR_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(SCALAR_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// File: sv/vgu_sqrt.sv
module vgu_sqrt import vgu_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SUM_W-1:0]  in_rad,
    input  sq_pay_t           in_pay,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output sq_pay_t           out_pay
);

    logic     vld_reg [ROOT_W];
    sqrt_st_t st_reg  [ROOT_W];
    sq_pay_t  pay_reg [ROOT_W];

    // one root bit per stage
    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        logic     vld_in;
        sqrt_st_t st_in;
        sqrt_st_t st_next;
        sq_pay_t  pay_in;

        if (g == 0) begin : g_first
            assign vld_in = in_valid;
            assign st_in  = {{REM_W{1'b0}}, {ROOT_W{1'b0}}, in_rad};
            assign pay_in = in_pay;
        end else begin : g_later
            assign vld_in = vld_reg[g-1];
            assign st_in  = st_reg[g-1];
            assign pay_in = pay_reg[g-1];
        end

        assign st_next = sqrt_step(st_in);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (en) begin
                vld_reg[g] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[g]  <= st_next;
                pay_reg[g] <= pay_in;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = st_reg[ROOT_W-1].root;
    assign out_pay   = pay_reg[ROOT_W-1];

endmodule

// File: sv/vgu_div.sv
module vgu_div import vgu_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2:0][MAG_W-1:0] in_mag,
    input  logic [MAG_W-1:0]      in_den,
    input  div_pay_t              in_pay,
    output logic                  out_valid,
    output logic [2:0][QUO_W-1:0] out_q,
    output div_pay_t              out_pay
);

    logic                  vld_reg [QUO_W];
    logic [MAG_W-1:0]      den_reg [QUO_W];
    logic [2:0][MAG_W-1:0] rem_reg [QUO_W];
    logic [2:0][QUO_W-1:0] q_reg   [QUO_W];
    div_pay_t              pay_reg [QUO_W];

    // one quotient bit per stage, three lanes share the divisor
    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        logic                  vld_in;
        logic [MAG_W-1:0]      den_in;
        logic [2:0][MAG_W-1:0] rem_in;
        logic [2:0]            bit_in;
        logic [2:0][QUO_W-1:0] q_in;
        div_pay_t              pay_in;
        logic [2:0][MAG_W-1:0] rem_next;
        logic [2:0][QUO_W-1:0] q_next;

        if (g == 0) begin : g_first
            // numerator is mag shifted up by the fraction width
            always_comb begin
                for (int l = 0; l < 3; l++) begin
                    rem_in[l] = {1'b0, in_mag[l][MAG_W-1:1]};
                    bit_in[l] = in_mag[l][0];
                end
            end
            assign vld_in = in_valid;
            assign den_in = in_den;
            assign q_in   = '0;
            assign pay_in = in_pay;
        end else begin : g_later
            assign vld_in = vld_reg[g-1];
            assign den_in = den_reg[g-1];
            assign rem_in = rem_reg[g-1];
            assign bit_in = 3'b000;
            assign q_in   = q_reg[g-1];
            assign pay_in = pay_reg[g-1];
        end

        always_comb begin
            logic [MAG_W:0] res;
            for (int l = 0; l < 3; l++) begin
                res         = div_step(rem_in[l], den_in, bit_in[l]);
                rem_next[l] = res[MAG_W-1:0];
                q_next[l]   = {q_in[l][QUO_W-2:0], res[MAG_W]};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (en) begin
                vld_reg[g] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[g] <= den_in;
                rem_reg[g] <= rem_next;
                q_reg[g]   <= q_next;
                pay_reg[g] <= pay_in;
            end
        end
    end

    assign out_valid = vld_reg[QUO_W-1];
    assign out_q     = q_reg[QUO_W-1];
    assign out_pay   = pay_reg[QUO_W-1];

endmodule

// File: sv/vector_geometry_unit.sv
// Vector geometry unit: takes one item per clock and returns one result per item, in
// order, through 5 stages of multiply and sum, 49 stages of square root, one per root
// bit, 31 stages of division, one per quotient bit, and the output register.
// Sustained rate is one item per cycle; a stall on the result side freezes the whole
// pipeline, so s_tready follows !m_tvalid || m_tready. Unit vectors come out in Q1.30,
// truncated toward zero; a zero norm gives a zero vector with m_tuser set. Dot product
// and squared distance come out in Q.24, clamped to 64 bits, distance in Q.12.
module vector_geometry_unit import vgu_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // action
    input  logic [2:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_x, out_y, out_z, scalar
    output logic [OUT_DATA_W-1:0] m_tdata,
    // zero_norm
    output logic                  m_tuser
);

    logic en;

    // stage 1: differences and products
    logic                     s1_vld_reg;
    action_t                  s1_act_reg;
    logic signed [CW-1:0]     s1_a_reg    [3];
    logic signed [DIFF_W-1:0] s1_diff_reg [3];
    logic signed [PROD_W-1:0] s1_prod_reg [9];
    logic signed [CW-1:0]     a_in [3];
    logic signed [CW-1:0]     b_in [3];
    logic signed [DIFF_W-1:0] s1_diff_next [3];
    logic signed [PROD_W-1:0] s1_prod_next [9];

    // stage 2: vector magnitudes and dot sum
    logic                     s2_vld_reg;
    action_t                  s2_act_reg;
    logic [2:0]               s2_neg_reg;
    logic [2:0][MAG_W-1:0]    s2_mag_reg;
    logic signed [DOT_W-1:0]  s2_dot_reg;
    logic signed [VEC_W-1:0]  s2_vec [3];
    logic [2:0]               s2_neg_next;
    logic [2:0][MAG_W-1:0]    s2_mag_next;
    logic signed [DOT_W-1:0]  s2_dot_next;

    // stage 3: partial products of the squares
    logic                     s3_vld_reg;
    action_t                  s3_act_reg;
    logic [2:0]               s3_neg_reg;
    logic [2:0][MAG_W-1:0]    s3_mag_reg;
    logic signed [DOT_W-1:0]  s3_dot_reg;
    logic [2:0][HH_W-1:0]     s3_hh_reg;
    logic [2:0][HL_W-1:0]     s3_hl_reg;
    logic [2:0][LL_W-1:0]     s3_ll_reg;
    logic [2:0][HH_W-1:0]     s3_hh_next;
    logic [2:0][HL_W-1:0]     s3_hl_next;
    logic [2:0][LL_W-1:0]     s3_ll_next;

    // stage 4: squares
    logic                     s4_vld_reg;
    action_t                  s4_act_reg;
    logic [2:0]               s4_neg_reg;
    logic [2:0][MAG_W-1:0]    s4_mag_reg;
    logic signed [DOT_W-1:0]  s4_dot_reg;
    logic [2:0][SQ_W-1:0]     s4_sq_reg;
    logic [2:0][SQ_W-1:0]     s4_sq_next;

    // stage 5: sum of squares
    logic                     s5_vld_reg;
    action_t                  s5_act_reg;
    logic [2:0]               s5_neg_reg;
    logic [2:0][MAG_W-1:0]    s5_mag_reg;
    logic signed [DOT_W-1:0]  s5_dot_reg;
    logic [SUM_W-1:0]         s5_sum_reg;

    // square root and divider
    sq_pay_t                  sq_in_pay;
    logic                     sq_vld;
    logic [ROOT_W-1:0]        sq_root;
    sq_pay_t                  sq_out_pay;
    div_pay_t                 dv_in_pay;
    logic                     dv_vld;
    logic [2:0][QUO_W-1:0]    dv_q;
    div_pay_t                 dv_out_pay;

    // output register
    logic                     m_tvalid_reg;
    logic [OUT_DATA_W-1:0]    m_tdata_reg;
    logic                     m_tuser_reg;
    logic [OUT_DATA_W-1:0]    m_tdata_next;
    logic                     m_tuser_next;

    // whole pipeline moves when the output register can take an item
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // stage 1 logic
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            a_in[k]         = s_tdata[k*CW +: CW];
            b_in[k]         = s_tdata[(k+3)*CW +: CW];
            s1_diff_next[k] = DIFF_W'(a_in[k]) - DIFF_W'(b_in[k]);
        end
        s1_prod_next[0] = PROD_W'(a_in[1]) * PROD_W'(b_in[2]);
        s1_prod_next[1] = PROD_W'(a_in[2]) * PROD_W'(b_in[1]);
        s1_prod_next[2] = PROD_W'(a_in[2]) * PROD_W'(b_in[0]);
        s1_prod_next[3] = PROD_W'(a_in[0]) * PROD_W'(b_in[2]);
        s1_prod_next[4] = PROD_W'(a_in[0]) * PROD_W'(b_in[1]);
        s1_prod_next[5] = PROD_W'(a_in[1]) * PROD_W'(b_in[0]);
        s1_prod_next[6] = PROD_W'(a_in[0]) * PROD_W'(b_in[0]);
        s1_prod_next[7] = PROD_W'(a_in[1]) * PROD_W'(b_in[1]);
        s1_prod_next[8] = PROD_W'(a_in[2]) * PROD_W'(b_in[2]);
    end

    // stage 2 logic: pick the vector per action, split sign and magnitude
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s2_vec[k] = '0;
        end
        case (s1_act_reg)
            ACT_UNIT_DIFF, ACT_DIST_SQ, ACT_DIST: begin
                for (int k = 0; k < 3; k++) begin
                    s2_vec[k] = VEC_W'(s1_diff_reg[k]);
                end
            end
            ACT_UNIT_CROSS: begin
                s2_vec[0] = VEC_W'(s1_prod_reg[0]) - VEC_W'(s1_prod_reg[1]);
                s2_vec[1] = VEC_W'(s1_prod_reg[2]) - VEC_W'(s1_prod_reg[3]);
                s2_vec[2] = VEC_W'(s1_prod_reg[4]) - VEC_W'(s1_prod_reg[5]);
            end
            ACT_UNIT_A: begin
                for (int k = 0; k < 3; k++) begin
                    s2_vec[k] = VEC_W'(s1_a_reg[k]);
                end
            end
            default: begin
            end
        endcase
        for (int k = 0; k < 3; k++) begin
            s2_neg_next[k] = s2_vec[k][VEC_W-1];
            s2_mag_next[k] = s2_vec[k][VEC_W-1] ? MAG_W'(-s2_vec[k]) : MAG_W'(s2_vec[k]);
        end
        s2_dot_next = DOT_W'(s1_prod_reg[6]) + DOT_W'(s1_prod_reg[7])
                    + DOT_W'(s1_prod_reg[8]);
    end

    // stage 3 logic: split each magnitude in two halves
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s3_hh_next[k] = HH_W'(s2_mag_reg[k][MAG_W-1:SPLIT_LO])
                          * HH_W'(s2_mag_reg[k][MAG_W-1:SPLIT_LO]);
            s3_hl_next[k] = HL_W'(s2_mag_reg[k][MAG_W-1:SPLIT_LO])
                          * HL_W'(s2_mag_reg[k][SPLIT_LO-1:0]);
            s3_ll_next[k] = LL_W'(s2_mag_reg[k][SPLIT_LO-1:0])
                          * LL_W'(s2_mag_reg[k][SPLIT_LO-1:0]);
        end
    end

    // stage 4 logic: recombine the partial products
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s4_sq_next[k] = (SQ_W'(s3_hh_reg[k]) << (2 * SPLIT_LO))
                          + (SQ_W'(s3_hl_reg[k]) << (SPLIT_LO + 1))
                          + SQ_W'(s3_ll_reg[k]);
        end
    end

    // pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s3_vld_reg   <= 1'b0;
            s4_vld_reg   <= 1'b0;
            s5_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg   <= s_tvalid;
            s2_vld_reg   <= s1_vld_reg;
            s3_vld_reg   <= s2_vld_reg;
            s4_vld_reg   <= s3_vld_reg;
            s5_vld_reg   <= s4_vld_reg;
            m_tvalid_reg <= dv_vld;
        end
    end

    // pipeline data
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_act_reg  <= action_t'(s_tuser);
            s1_a_reg    <= a_in;
            s1_diff_reg <= s1_diff_next;
            s1_prod_reg <= s1_prod_next;

            s2_act_reg  <= s1_act_reg;
            s2_neg_reg  <= s2_neg_next;
            s2_mag_reg  <= s2_mag_next;
            s2_dot_reg  <= s2_dot_next;

            s3_act_reg  <= s2_act_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_mag_reg  <= s2_mag_reg;
            s3_dot_reg  <= s2_dot_reg;
            s3_hh_reg   <= s3_hh_next;
            s3_hl_reg   <= s3_hl_next;
            s3_ll_reg   <= s3_ll_next;

            s4_act_reg  <= s3_act_reg;
            s4_neg_reg  <= s3_neg_reg;
            s4_mag_reg  <= s3_mag_reg;
            s4_dot_reg  <= s3_dot_reg;
            s4_sq_reg   <= s4_sq_next;

            s5_act_reg  <= s4_act_reg;
            s5_neg_reg  <= s4_neg_reg;
            s5_mag_reg  <= s4_mag_reg;
            s5_dot_reg  <= s4_dot_reg;
            s5_sum_reg  <= s4_sq_reg[0] + s4_sq_reg[1] + s4_sq_reg[2];

            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    // scalar results that need no root
    always_comb begin
        sq_in_pay.action = s5_act_reg;
        sq_in_pay.neg    = s5_neg_reg;
        sq_in_pay.mag    = s5_mag_reg;
        case (s5_act_reg)
            ACT_DOT:     sq_in_pay.scalar = sat_s64(WIDE_W'(s5_dot_reg));
            ACT_DIST_SQ: sq_in_pay.scalar = sat_s64({1'b0, s5_sum_reg});
            default:     sq_in_pay.scalar = '0;
        endcase
    end

    vgu_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s5_vld_reg),
        .in_rad    (s5_sum_reg),
        .in_pay    (sq_in_pay),
        .out_valid (sq_vld),
        .out_root  (sq_root),
        .out_pay   (sq_out_pay)
    );

    // distance is the root itself
    always_comb begin
        dv_in_pay.action = sq_out_pay.action;
        dv_in_pay.neg    = sq_out_pay.neg;
        dv_in_pay.zero   = (sq_root == '0);
        if (sq_out_pay.action == ACT_DIST) begin
            dv_in_pay.scalar = SCALAR_W'(sq_root);
        end else begin
            dv_in_pay.scalar = sq_out_pay.scalar;
        end
    end

    vgu_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_vld),
        .in_mag    (sq_out_pay.mag),
        .in_den    (sq_root),
        .in_pay    (dv_in_pay),
        .out_valid (dv_vld),
        .out_q     (dv_q),
        .out_pay   (dv_out_pay)
    );

    // clamp, apply sign, mask per action
    always_comb begin
        logic             is_vec;
        logic [QUO_W-1:0] qs;
        logic [OUT_W-1:0] comp;
        is_vec = (dv_out_pay.action == ACT_UNIT_DIFF) || (dv_out_pay.action == ACT_UNIT_CROSS)
              || (dv_out_pay.action == ACT_UNIT_A);
        for (int k = 0; k < 3; k++) begin
            qs   = (dv_q[k] > UNIT_ONE) ? UNIT_ONE : dv_q[k];
            comp = dv_out_pay.neg[k] ? -OUT_W'(qs) : OUT_W'(qs);
            m_tdata_next[k*OUT_W +: OUT_W] = (is_vec && !dv_out_pay.zero) ? comp : '0;
        end
        m_tdata_next[3*OUT_W +: SCALAR_W] = dv_out_pay.scalar;
        m_tuser_next = is_vec && dv_out_pay.zero;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a zero norm item carries a zero vector
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[3*OUT_W-1:0] == '0)
        else $error("zero norm item with nonzero vector");

    // a scalar result never comes with a vector or the flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[3*OUT_W +: SCALAR_W] != '0)
        |-> !m_tuser && (m_tdata[3*OUT_W-1:0] == '0))
        else $error("scalar and vector result mixed");

    // a stalled pipeline keeps the item in its first stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_vld_reg && !en |=> s1_vld_reg)
        else $error("item lost in first stage during stall");

endmodule
